// ----- hw/rtl/crcdf_pkg.sv -----
`default_nettype none
// crcdf_pkg: shared types, constants and the crc32 byte update for the packet deframer
// no dependencies

package crcdf_pkg;

    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;

    // register word index
    localparam int unsigned REG_START_DELIM = 0;

    localparam logic [15:0] HDR_BYTES  = 16'd8;
    localparam logic [15:0] CRC_BYTES  = 16'd4;
    localparam logic [15:0] HUNT_DEPTH = 16'd3;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef struct packed {
        logic        is_payload;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic        crc_ok;
        logic [7:0]  pkt_type;
        logic [7:0]  seq_num;
        logic [15:0] pkt_length;
    } result_t;

    // reflected crc32, one byte, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crc_checked_packet_deframer_top.sv -----
`default_nettype none
// crc_checked_packet_deframer_top: delimiter hunt, header capture, payload pass-through, crc32 check
// depends on crcdf_pkg

// One received byte enters per word on the s_ channel and the block takes a word
// every cycle unless the skid slot is full; a result leaves on the m_ channel through
// the input register and then the result register, with a skid register so a stalled
// m_ side does not stop input until both output slots are full. The per-cycle work is
// at most one crc32 byte update plus the phase step. The deframer hunts for the
// configured 32-bit sync marker (msb byte first), reads an 8-byte header (big-endian
// crc, type, sequence, big-endian length) and then passes each payload byte out as one
// word; the word that completes the packet carries frame_end and crc_ok. A zero-length
// packet ends with a single non-payload word on its last header byte. On a crc mismatch
// the block reports crc_ok low and goes back to hunting. The marker register sits at APB
// address 0 and should be written only while the block is idle.

module crc_checked_packet_deframer_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [crcdf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [crcdf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [crcdf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                      pready,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [7:0]                           s_rx_byte,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_is_payload,
    output logic      [7:0]                           m_payload_byte,
    output logic                                      m_frame_end,
    output logic                                      m_crc_ok,
    output logic      [7:0]                           m_pkt_type,
    output logic      [7:0]                           m_seq_num,
    output logic      [15:0]                          m_pkt_length
);

    // configuration
    logic [31:0] start_delim_reg;
    logic        cfg_wr;

    // single register, every byte address of the word maps to it
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = start_delim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delim_reg <= '0;
        end else if (cfg_wr) begin
            start_delim_reg <= pwdata;
        end
    end

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       skid_valid_reg, skid_valid_next;

    assign advance       = in_valid_reg && !skid_valid_reg;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // deframer state
    crcdf_pkg::phase_t phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] exp_crc_reg, exp_crc_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] count_inc;
    logic        hdr_last;
    logic        data_end;

    assign count_inc = count_reg + 16'd1;
    assign hdr_last  = (count_inc == crcdf_pkg::HDR_BYTES);
    assign data_end  = (count_inc >= length_reg);

    always_comb begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        count_next   = count_reg;
        exp_crc_next = exp_crc_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        length_next  = length_reg;
        crc_next     = crc_reg;
        if (advance) begin
            unique case (phase_reg)
                crcdf_pkg::PH_HEADER: begin
                    if (count_reg < crcdf_pkg::CRC_BYTES) begin
                        // crc field counts as zeros
                        exp_crc_next = {exp_crc_reg[23:0], in_byte_reg};
                        crc_next     = crcdf_pkg::crc_byte(crc_reg, 8'h00);
                    end else begin
                        crc_next = crcdf_pkg::crc_byte(crc_reg, in_byte_reg);
                        case (count_reg[1:0])
                            2'd0:    type_next   = in_byte_reg;
                            2'd1:    seq_next    = in_byte_reg;
                            2'd2:    length_next = {in_byte_reg, 8'h00};
                            default: length_next = {length_reg[15:8], in_byte_reg};
                        endcase
                    end
                    count_next = count_inc;
                    if (hdr_last) begin
                        count_next = '0;
                        if (length_next == 16'd0) begin
                            phase_next  = crcdf_pkg::PH_HUNT;
                            window_next = '0;
                        end else begin
                            phase_next = crcdf_pkg::PH_DATA;
                        end
                    end
                end
                crcdf_pkg::PH_DATA: begin
                    crc_next = crcdf_pkg::crc_byte(crc_reg, in_byte_reg);
                    if (data_end) begin
                        phase_next  = crcdf_pkg::PH_HUNT;
                        window_next = '0;
                        count_next  = '0;
                    end else begin
                        count_next = count_inc;
                    end
                end
                default: begin
                    if ((count_reg >= crcdf_pkg::HUNT_DEPTH)
                        && ({window_reg, in_byte_reg} == start_delim_reg)) begin
                        phase_next  = crcdf_pkg::PH_HEADER;
                        window_next = '0;
                        count_next  = '0;
                        crc_next    = crcdf_pkg::CRC_INIT;
                    end else begin
                        phase_next  = crcdf_pkg::PH_HUNT;
                        window_next = {window_reg[15:0], in_byte_reg};
                        if (count_reg < crcdf_pkg::HUNT_DEPTH) begin
                            count_next = count_inc;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= crcdf_pkg::PH_HUNT;
            window_reg  <= '0;
            count_reg   <= '0;
            exp_crc_reg <= '0;
            type_reg    <= '0;
            seq_reg     <= '0;
            length_reg  <= '0;
            crc_reg     <= crcdf_pkg::CRC_INIT;
        end else begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            count_reg   <= count_next;
            exp_crc_reg <= exp_crc_next;
            type_reg    <= type_next;
            seq_reg     <= seq_next;
            length_reg  <= length_next;
            crc_reg     <= crc_next;
        end
    end

    // result of this word
    logic               res_valid;
    crcdf_pkg::result_t res;

    always_comb begin
        res_valid        = 1'b0;
        res.is_payload   = 1'b0;
        res.payload_byte = 8'h00;
        res.frame_end    = 1'b0;
        res.crc_ok       = 1'b0;
        res.pkt_type     = type_next;
        res.seq_num      = seq_next;
        res.pkt_length   = length_next;
        unique case (phase_reg)
            crcdf_pkg::PH_HEADER: begin
                // zero-length packet ends on its last header byte
                if (hdr_last && (length_next == 16'd0)) begin
                    res_valid     = advance;
                    res.frame_end = 1'b1;
                    res.crc_ok    = (~crc_next == exp_crc_next);
                end
            end
            crcdf_pkg::PH_DATA: begin
                res_valid        = advance;
                res.is_payload   = 1'b1;
                res.payload_byte = in_byte_reg;
                res.frame_end    = data_end;
                res.crc_ok       = data_end && (~crc_next == exp_crc_next);
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // result register plus skid slot
    logic               out_valid_reg, out_valid_next;
    crcdf_pkg::result_t out_reg, out_next;
    crcdf_pkg::result_t skid_reg, skid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_is_payload   = out_reg.is_payload;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_frame_end    = out_reg.frame_end;
    assign m_crc_ok       = out_reg.crc_ok;
    assign m_pkt_type     = out_reg.pkt_type;
    assign m_seq_num      = out_reg.seq_num;
    assign m_pkt_length   = out_reg.pkt_length;

endmodule

`default_nettype wire
